// ===== hdl/rfidcrc_pkg.sv =====
package rfidcrc_pkg;

	localparam int unsigned CrcW     = 16;
	localparam int unsigned Crc5W    = 5;
	localparam int unsigned ByteW    = 8;
	localparam int unsigned CountW   = 4;

	localparam logic [CrcW-1:0]   Poly16    = 16'h1021;
	localparam logic [CrcW-1:0]   Preset16  = 16'hFFFF;
	localparam logic [CrcW-1:0]   Residue16 = 16'h1D0F;
	localparam logic [Crc5W-1:0]  Poly5     = 5'h09;
	localparam logic [Crc5W-1:0]  Preset5   = 5'h09;
	localparam logic [CountW-1:0] MaxBits   = 4'd8;

	typedef enum logic {
		MODE_CRC16 = 1'b0,
		MODE_CRC5  = 1'b1
	} crc_mode_t;

	typedef struct packed {
		logic [CrcW-1:0] crc_value;
		logic            residue_ok;
	} result_t;

	typedef struct packed {
		logic [CrcW-1:0] crc_next;
		result_t         result;
	} upd_t;

	function automatic logic [CrcW-1:0] preset_for(crc_mode_t mode);
		logic [CrcW-1:0] p;
		begin
			if (mode == MODE_CRC5) begin
				p = {{(CrcW-Crc5W){1'b0}}, Preset5};
			end else begin
				p = Preset16;
			end
			return p;
		end
	endfunction

endpackage

// ===== hdl/rfid_crc16_crc5_bit_engine_unit.sv =====
// Bit-granular CRC engine for the RFID air interface. Each input transaction
// carries one data byte whose leading bit_count bits (msb first, counts above
// eight act as eight, zero adds no bits) feed either CRC-16 CCITT (poly 0x1021,
// preset 0xFFFF) or CRC-5 (poly 0x09, preset 0x09), chosen by the one-bit mode
// register on the cfg channel. Writing the mode presets the CRC and drops any
// frame in progress; write it only while the engine is idle. The transaction
// with tlast high closes the frame and produces one result: the complemented
// CRC-16 or the 5-bit CRC in the low bits, with tuser set when the raw CRC-16
// equals the residue 0x1D0F. The engine then presets for the next frame.
// Throughput is one transaction per clock. A transaction is captured in the
// input register, and a closing transaction's result is loaded from there into
// the output register, which drives m_tvalid. The rate is set by the CRC
// register loop, which goes through the eight-step unrolled update once per
// cycle. A result waits in the output register; transactions that do not close
// a frame keep flowing while it is held, but a closing transaction waits in the
// input register until the held result is taken.
module rfid_crc16_crc5_bit_engine_unit import rfidcrc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [0:0]  cfg_data,    // crc_mode
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,     // [7:0] data_byte, [11:8] bit_count, [15:12] zero
	input  logic        s_tlast,     // frame_end
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,     // [15:0] crc_value
	output logic        m_tuser      // residue_ok
);

	// input stage
	logic              valid_s1;
	logic [ByteW-1:0]  data_s1;
	logic [CountW-1:0] count_s1;
	logic              last_s1;

	// state
	crc_mode_t         mode_q;
	logic [CrcW-1:0]   crc_q;

	logic    out_free;
	logic    fire_s1;
	logic    cfg_write;
	upd_t    upd;
	result_t out_result;

	// a stage-1 item moves on unless it closes a frame while a result is still held
	assign fire_s1   = valid_s1 && (!last_s1 || out_free);
	assign s_tready  = !valid_s1 || fire_s1;
	assign cfg_ready = 1'b1;
	assign cfg_write = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			data_s1  <= s_tdata[ByteW-1:0];
			count_s1 <= s_tdata[ByteW+CountW-1:ByteW];
			last_s1  <= s_tlast;
		end
	end

	// crc register: preset on mode write and after each closed frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_CRC16;
			crc_q  <= Preset16;
		end else if (cfg_write) begin
			mode_q <= crc_mode_t'(cfg_data[0]);
			crc_q  <= preset_for(crc_mode_t'(cfg_data[0]));
		end else if (fire_s1) begin
			crc_q  <= last_s1 ? preset_for(mode_q) : upd.crc_next;
		end
	end

	rfidcrc_update u_update (
		.mode      (mode_q),
		.crc_in    (crc_q),
		.data_byte (data_s1),
		.bit_count (count_s1),
		.upd       (upd)
	);

	rfidcrc_out_stage u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (fire_s1 && last_s1),
		.result     (upd.result),
		.free       (out_free),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_result (out_result)
	);

	assign m_tdata = out_result.crc_value;
	assign m_tuser = out_result.residue_ok;

	// crc-5 mode never leaves bits above the 5-bit register
	a_crc5_narrow: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == MODE_CRC5) |-> (crc_q[CrcW-1:Crc5W] == '0))
		else $error("crc-5 register has upper bits set");

	// a residue hit can only come with the complemented residue as value
	a_residue_value: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> (m_tdata == ~Residue16))
		else $error("residue flag without matching crc value");

	// a held stage-1 item is not dropped and keeps its data byte and frame end
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !fire_s1) |=> (valid_s1 && $stable(data_s1) && $stable(last_s1)))
		else $error("stalled stage-1 item lost");

endmodule

// ===== hdl/rfidcrc_update.sv =====
module rfidcrc_update import rfidcrc_pkg::*; (
	input  crc_mode_t         mode,
	input  logic [CrcW-1:0]   crc_in,
	input  logic [ByteW-1:0]  data_byte,
	input  logic [CountW-1:0] bit_count,
	output upd_t              upd
);

	logic [CountW-1:0] count_sat;
	logic [CrcW-1:0]   c16;
	logic [Crc5W-1:0]  c5;
	logic [CrcW-1:0]   crc_new;

	assign count_sat = (bit_count > MaxBits) ? MaxBits : bit_count;

	// eight msb-first bit steps, each gated by the bit count
	always_comb begin
		c16 = crc_in;
		c5  = crc_in[Crc5W-1:0];
		for (int i = 0; i < ByteW; i++) begin
			if (CountW'(i) < count_sat) begin
				if (c16[CrcW-1] ^ data_byte[ByteW-1-i]) begin
					c16 = {c16[CrcW-2:0], 1'b0} ^ Poly16;
				end else begin
					c16 = {c16[CrcW-2:0], 1'b0};
				end
				if (c5[Crc5W-1] ^ data_byte[ByteW-1-i]) begin
					c5 = {c5[Crc5W-2:0], 1'b0} ^ Poly5;
				end else begin
					c5 = {c5[Crc5W-2:0], 1'b0};
				end
			end
		end
	end

	assign crc_new = (mode == MODE_CRC5) ? {{(CrcW-Crc5W){1'b0}}, c5} : c16;

	assign upd.crc_next            = crc_new;
	assign upd.result.crc_value    = (mode == MODE_CRC5) ? crc_new : ~crc_new;
	assign upd.result.residue_ok   = (mode == MODE_CRC16) && (crc_new == Residue16);

endmodule

// ===== hdl/rfidcrc_out_stage.sv =====
module rfidcrc_out_stage import rfidcrc_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    load,
	input  result_t result,
	output logic    free,
	output logic    out_valid,
	input  logic    out_ready,
	output result_t out_result
);

	logic    valid_q;
	result_t result_q;

	assign free       = !valid_q || out_ready;
	assign out_valid  = valid_q;
	assign out_result = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			result_q <= result;
		end
	end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
	import rfidcrc_pkg::*;

	localparam int unsigned CycleLimit = 400000;
	localparam int unsigned SettleCycles = 4;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [0:0]  cfg_data = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;
	logic        m_tuser;

	// own copy of the engine state
	crc_mode_t       crc_mode_q = MODE_CRC16;
	logic [CrcW-1:0] crc_state = Preset16;
	result_t         expected_crcs[$];

	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned mismatches = 0;
	int unsigned cycle_count = 0;

	rfid_crc16_crc5_bit_engine_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	always #6 clk = ~clk;

	function automatic logic [CrcW-1:0] crc_preset(crc_mode_t mode);
		return (mode == MODE_CRC5) ? {{(CrcW-Crc5W){1'b0}}, Preset5} : Preset16;
	endfunction

	// clock the leading bits of one byte through the crc, msb first
	function automatic logic [CrcW-1:0] crc_shift_in(crc_mode_t mode, logic [CrcW-1:0] crc,
			logic [ByteW-1:0] data_byte, logic [CountW-1:0] bit_count);
		int unsigned nbits;
		logic        fb;
		nbits = (bit_count > MaxBits) ? MaxBits : bit_count;
		for (int i = 0; i < nbits; i++) begin
			if (mode == MODE_CRC5) begin
				fb = crc[Crc5W-1] ^ data_byte[ByteW-1-i];
				crc = {crc[CrcW-2:0], 1'b0} & 16'h001F;
				if (fb)
					crc = crc ^ {{(CrcW-Crc5W){1'b0}}, Poly5};
			end else begin
				fb = crc[CrcW-1] ^ data_byte[ByteW-1-i];
				crc = {crc[CrcW-2:0], 1'b0};
				if (fb)
					crc = crc ^ Poly16;
			end
		end
		return crc;
	endfunction

	task automatic report_mismatch(input string what);
		if (mismatches < 100)
			$display("ERROR at %0t: %s", $realtime, what);
		mismatches++;
	endtask

	// one input transaction; the expected crc is worked out once it is accepted
	task automatic send_item(input logic [ByteW-1:0] data_byte, input logic [CountW-1:0] bit_count,
			input logic frame_end);
		result_t r;
		if ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {4'h0, bit_count, data_byte};
		s_tlast  <= frame_end;
		do @(posedge clk); while (!s_tready);
		crc_state = crc_shift_in(crc_mode_q, crc_state, data_byte, bit_count);
		if (frame_end) begin
			if (crc_mode_q == MODE_CRC5) begin
				r.crc_value  = crc_state & 16'h001F;
				r.residue_ok = 1'b0;
			end else begin
				r.crc_value  = ~crc_state;
				r.residue_ok = (crc_state == Residue16);
			end
			expected_crcs.push_back(r);
			crc_state = crc_preset(crc_mode_q);
		end
	endtask

	// mode writes only once the engine has gone quiet
	task automatic write_crc_mode(input crc_mode_t mode);
		s_tvalid <= 1'b0;
		while (expected_crcs.size() != 0)
			@(posedge clk);
		repeat (SettleCycles) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= mode;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		crc_mode_q = mode;
		crc_state = crc_preset(mode);
	endtask

	// random bytes followed by their own crc, so the check bits close the frame
	task automatic send_frame_with_crc(input int unsigned len);
		logic [CrcW-1:0] fcs;
		for (int i = 0; i < len; i++)
			send_item(ByteW'($urandom_range(255)), MaxBits, 1'b0);
		if (crc_mode_q == MODE_CRC16) begin
			fcs = ~crc_state;
			send_item(fcs[15:8], MaxBits, 1'b0);
			send_item(fcs[7:0], MaxBits, 1'b1);
		end else begin
			send_item({crc_state[Crc5W-1:0], 3'b000}, 4'd5, 1'b1);
		end
	endtask

	task automatic test_crc16_directed;
		write_crc_mode(MODE_CRC16);
		send_item(8'h00, 4'd8, 1'b1);
		send_item(8'hFF, 4'd8, 1'b1);
		send_item(8'hA5, 4'd1, 1'b1);
		// zero bits on a lone closing item: crc of the bare preset
		send_item(8'h5A, 4'd0, 1'b1);
		// counts above eight behave as eight
		send_item(8'h3C, 4'd15, 1'b1);
		send_item(8'h81, 4'd3, 1'b0);
		send_item(8'h7E, 4'd9, 1'b0);
		send_item(8'hC3, 4'd0, 1'b1);
		// frame plus its own crc lands on the residue
		send_frame_with_crc(2);
	endtask

	task automatic test_crc5_directed;
		write_crc_mode(MODE_CRC5);
		send_item(8'hFF, 4'd8, 1'b1);
		send_item(8'h00, 4'd0, 1'b1);
		send_item(8'h96, 4'd12, 1'b1);
		send_item(8'h4B, 4'd7, 1'b1);
		send_frame_with_crc(2);
	endtask

	// a mode write drops the frame in progress
	task automatic test_mode_switch_mid_frame;
		write_crc_mode(MODE_CRC16);
		send_item(8'h12, 4'd8, 1'b0);
		send_item(8'h34, 4'd4, 1'b0);
		write_crc_mode(MODE_CRC5);
		send_item(8'hE7, 4'd6, 1'b0);
		write_crc_mode(MODE_CRC5);
		send_item(8'h5C, 4'd8, 1'b1);
		send_item(8'h99, 4'd2, 1'b0);
		write_crc_mode(MODE_CRC16);
		send_item(8'h99, 4'd2, 1'b1);
	endtask

	task automatic test_random_traffic(input int unsigned idle_pct, input int unsigned stall_pct);
		int unsigned sent;
		int unsigned pick;
		int unsigned len;
		logic [CountW-1:0] nbits;
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		for (int seg = 0; seg < 4; seg++) begin
			write_crc_mode(crc_mode_t'($urandom_range(1)));
			sent = 0;
			while (sent < 50) begin
				pick = $urandom_range(99);
				if (pick < 10) begin
					// noise, including stray frame ends
					send_item(ByteW'($urandom_range(255)), CountW'($urandom_range(15)),
						1'($urandom_range(1)));
					sent++;
				end else if (pick < 25) begin
					len = $urandom_range(1, 6);
					send_frame_with_crc(len);
					sent += len + 2;
				end else begin
					len = $urandom_range(1, 10);
					for (int i = 0; i < len; i++) begin
						pick = $urandom_range(99);
						if (pick < 5)
							nbits = 4'd0;
						else if (pick < 10)
							nbits = CountW'($urandom_range(15, 9));
						else if (pick < 70)
							nbits = MaxBits;
						else
							nbits = CountW'($urandom_range(7, 1));
						send_item(ByteW'($urandom_range(255)), nbits, i == len - 1);
					end
					sent += len;
				end
			end
		end
	endtask

	// result side: check on each accepted transaction, then pick the next ready
	always @(posedge clk) begin
		result_t exp_r;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_crcs.size() == 0) begin
				report_mismatch($sformatf("unexpected result crc=%h residue=%b", m_tdata, m_tuser));
			end else begin
				exp_r = expected_crcs.pop_front();
				if (m_tdata !== exp_r.crc_value)
					report_mismatch($sformatf("crc_value %h, expected %h", m_tdata,
						exp_r.crc_value));
				if (m_tuser !== exp_r.residue_ok)
					report_mismatch($sformatf("residue_ok %b, expected %b", m_tuser,
						exp_r.residue_ok));
			end
		end
		m_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CycleLimit) begin
			$display("rfid_crc16_crc5_bit_engine_unit: mismatch");
			$finish;
		end
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_crc16_directed();
		test_crc5_directed();
		test_mode_switch_mid_frame();
		test_random_traffic(0, 0);
		test_random_traffic(71, 0);
		test_random_traffic(0, 71);
		test_random_traffic(15, 15);
		s_tvalid <= 1'b0;
		while (expected_crcs.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("rfid_crc16_crc5_bit_engine_unit: match");
		else
			$display("rfid_crc16_crc5_bit_engine_unit: mismatch");
		$finish;
	end

endmodule

// ===== sim.f =====
hdl/rfidcrc_pkg.sv
hdl/rfidcrc_update.sv
hdl/rfidcrc_out_stage.sv
hdl/rfid_crc16_crc5_bit_engine_unit.sv
verif/testbench.sv
